// ----- design/ordered_list_append_search_remove_macros.svh -----
// Assertion macros used by the ordered list top level.
// Depends on nothing; each use names the clock and reset of the including module.
`ifndef ORDERED_LIST_APPEND_SEARCH_REMOVE_MACROS_SVH
`define ORDERED_LIST_APPEND_SEARCH_REMOVE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLASR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLASR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/olasr_pkg.sv -----
// Types and codes for the ordered list block.
// Used by olasr_cell and ordered_list_append_search_remove; depends on nothing.
package olasr_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DUMP = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]         done_kind;
        logic [1:0]         status;
        logic signed [31:0] entry;
        logic               last;
    } t_result;

    // Per-cell controls: capture a compare, load a new value, take the
    // neighbour's value, or take the head value (wrap of a dump rotation).
    typedef struct packed {
        logic cmp;
        logic load;
        logic shift;
        logic wrap;
    } t_cell_ctl;

endpackage

// ----- design/olasr_cell.sv -----
// One storage cell of the ordered list: holds an entry and a registered match flag.
// Depends on olasr_pkg.
module olasr_cell (
    input  logic                  i_clk,
    input  olasr_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_value,
    input  logic signed [31:0]    i_next,
    input  logic signed [31:0]    i_head,
    output logic signed [31:0]    o_data,
    output logic                  o_match
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift) begin
            n_data = i_next;
        end else if (i_ctl.wrap) begin
            n_data = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp) begin
            r_match <= i_valid && (r_data == i_value);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ----- design/ordered_list_append_search_remove.sv -----
// Top level of the ordered list: a row of olasr_cell instances and the sequencer.
// Depends on olasr_pkg, olasr_cell and ordered_list_append_search_remove_macros.svh.
//
// Usage
//   A transaction is taken on the rising edge where start is high and busy is low;
//   i_item carries the kind (append, search, remove, dump) and the value.
//   Results appear on o_result for exactly one cycle, marked by o_strobe. The
//   receiver cannot stall, so every strobed result must be taken when shown.
// Timing
//   In the accept cycle every cell compares its entry against the value and
//   registers a match flag. The next cycle (execute) resolves the operation:
//   append loads the cell at the tail, remove finds the first match with one
//   wide add over the match vector and shifts the later cells one place toward
//   the head, search ORs the match flags. The single result shows in the cycle
//   after execute, and busy is already low then, so a new transaction can be
//   taken while it shows. Dump of N entries rotates the row of cells N times,
//   emitting the head cell each cycle, so the row is back in order at the end:
//   N results on consecutive cycles. Dump of an empty list gives one result
//   with status empty.
// Reset
//   Synchronous, active low: the entry count clears and the sequencer returns to
//   idle. Cell contents are not cleared; only cells below the count are read.
`include "ordered_list_append_search_remove_macros.svh"

module ordered_list_append_search_remove #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  olasr_pkg::t_item   i_item,
    output logic               o_strobe,
    output olasr_pkg::t_result o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    olasr_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_left, n_left;
    logic [1:0]           r_kind;
    logic signed [31:0]   r_value;
    logic                 r_strobe, n_strobe;
    olasr_pkg::t_result   r_result, n_result;

    logic                 w_accept;
    logic signed [31:0]   w_cell_value;
    logic signed [31:0]   w_data [DEPTH];
    logic [DEPTH-1:0]     w_match;
    logic [DEPTH-1:0]     w_from_first;
    logic                 w_any_match;
    logic                 w_full;
    olasr_pkg::t_cell_ctl w_ctl [DEPTH];
    logic [DEPTH-1:0]     w_valid;
    logic                 w_append_ok;
    logic                 w_last_out;

    assign w_accept     = start && (r_state == olasr_pkg::S_IDLE);
    assign w_cell_value = (r_state == olasr_pkg::S_IDLE) ? i_item.value : r_value;
    assign w_any_match  = |w_match;
    // Negation keeps the lowest match and flips every bit above it; OR with the
    // match vector to set every bit from the lowest match upward.
    assign w_from_first = w_match | (~w_match + DEPTH'(1));
    assign w_full       = (r_count == CW'(DEPTH));

    // Per-cell controls: each cell decodes its own index against the count.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_valid[i]       = (CW'(i) < r_count);
            w_ctl[i].cmp     = w_accept;
            w_ctl[i].load    = (r_state == olasr_pkg::S_EXEC)
                               && (r_kind == olasr_pkg::KIND_APPEND)
                               && !w_full && (CW'(i) == r_count);
            w_ctl[i].shift   = ((r_state == olasr_pkg::S_EXEC)
                                && (r_kind == olasr_pkg::KIND_REMOVE)
                                && w_any_match && w_from_first[i])
                               || ((r_state == olasr_pkg::S_DUMP)
                                   && ((CW + 1)'(i + 1) < {1'b0, r_count}));
            w_ctl[i].wrap    = (r_state == olasr_pkg::S_DUMP)
                               && ((CW + 1)'(i + 1) == {1'b0, r_count});
        end
    end

    // Row of cells; the tail cell's neighbour input is the head (dump wrap).
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_next;
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_data[0];
        end else begin : g_body
            assign w_next = w_data[g + 1];
        end
        olasr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_valid (w_valid[g]),
            .i_value (w_cell_value),
            .i_next  (w_next),
            .i_head  (w_data[0]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // Sequencer: next state, count and the registered result.
    always_comb begin
        n_state            = r_state;
        n_count            = r_count;
        n_left             = r_left;
        n_strobe           = 1'b0;
        n_result           = r_result;
        n_result.done_kind = r_kind;
        n_result.status    = olasr_pkg::ST_OK;
        n_result.entry     = 32'sd0;
        n_result.last      = 1'b1;
        case (r_state)
            olasr_pkg::S_IDLE: begin
                if (start) begin
                    n_state = olasr_pkg::S_EXEC;
                end
            end
            olasr_pkg::S_EXEC: begin
                case (r_kind)
                    olasr_pkg::KIND_APPEND: begin
                        n_strobe = 1'b1;
                        n_state  = olasr_pkg::S_IDLE;
                        if (w_full) begin
                            n_result.status = olasr_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    olasr_pkg::KIND_SEARCH: begin
                        n_strobe        = 1'b1;
                        n_state         = olasr_pkg::S_IDLE;
                        n_result.status = w_any_match ? olasr_pkg::ST_OK
                                                      : olasr_pkg::ST_NOT_FOUND;
                    end
                    olasr_pkg::KIND_REMOVE: begin
                        n_strobe = 1'b1;
                        n_state  = olasr_pkg::S_IDLE;
                        if (w_any_match) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_result.status = olasr_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_strobe        = 1'b1;
                            n_state         = olasr_pkg::S_IDLE;
                            n_result.status = olasr_pkg::ST_EMPTY;
                        end else begin
                            n_left  = r_count;
                            n_state = olasr_pkg::S_DUMP;
                        end
                    end
                endcase
            end
            olasr_pkg::S_DUMP: begin
                // Emit the head, rotate the row, advance the countdown.
                n_strobe       = 1'b1;
                n_result.entry = w_data[0];
                n_result.last  = (r_left == CW'(1));
                n_left         = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = olasr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olasr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= olasr_pkg::S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    // Hold the transaction fields for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_item.kind;
            r_value <= i_item.value;
        end
        r_result <= n_result;
    end

    assign busy     = (r_state != olasr_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign w_append_ok = o_strobe && (o_result.done_kind == olasr_pkg::KIND_APPEND)
                         && (o_result.status == olasr_pkg::ST_OK);
    assign w_last_out  = o_strobe && o_result.last;

    `OLASR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count over")
    `OLASR_ASSERT_IMP(a_append_grows, i_clk, i_rst_n, w_append_ok, r_count == $past(r_count) + CW'(1), "no growth")
    `OLASR_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, w_last_out, !busy, "last while busy")
    `OLASR_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == olasr_pkg::S_EXEC, "not executed")

endmodule
